// ----- rtl/core/fltw_pkg.sv -----
// Shared types and constants for the four-level page table walker.
// No dependencies; every other file of the walker refers to this package.
`default_nettype none

package fltw_pkg;

  localparam int unsigned PA_W = 52;
  localparam int unsigned VA_W = 64;
  localparam int unsigned SAVED_W = 48;
  localparam int unsigned PAB_W = 6;
  localparam int unsigned CFG_IDX_W = 1;

  // request command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_ENTRY = 1'b1;

  // result kind codes
  localparam logic KIND_REQ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROOT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PABITS = 1'b1;

  // entry bit positions
  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_RW = 1;
  localparam int unsigned BIT_US = 2;
  localparam int unsigned BIT_PWT = 3;
  localparam int unsigned BIT_PCD = 4;
  localparam int unsigned BIT_ACC = 5;
  localparam int unsigned BIT_DIRTY = 6;
  localparam int unsigned BIT_HUGE = 7;
  localparam int unsigned BIT_GLOBAL = 8;
  localparam int unsigned BIT_NX = 63;

  localparam logic [15:0] UPPER_ONES = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NONCANON  = 3'd1,
    ST_NOTMAPPED = 3'd2,
    ST_HUGE      = 3'd3,
    ST_CORRUPT   = 3'd4
  } status_t;

  typedef struct packed {
    logic [PA_W-1:0] root;
    logic [PA_W-1:0] mask;   // valid frame bits, 11..0 always clear
  } cfg_t;

  typedef struct packed {
    logic            cmd;
    logic [VA_W-1:0] vaddr;
    logic [VA_W-1:0] entry_value;
  } item_t;

  typedef struct packed {
    logic            kind;
    logic [PA_W-1:0] read_address;
    status_t         status;
    logic [PA_W-1:0] paddr;
    logic            writable;
    logic            user;
    logic            no_execute;
    logic            write_through;
    logic            cache_disable;
    logic            global_page;
    logic            accessed;
    logic            dirty;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/fltw_in_if.sv -----
// Request channel of the page table walker: valid/ready plus payload.
// Depends on fltw_pkg for field widths.
`default_nettype none

interface fltw_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [fltw_pkg::VA_W-1:0]     vaddr;
  logic [fltw_pkg::VA_W-1:0]     entry_value;

  modport source (output valid, output cmd, output vaddr, output entry_value,
                  input ready);
  modport sink (input valid, input cmd, input vaddr, input entry_value,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fltw_out_if.sv -----
// Result channel of the page table walker: valid/ready plus payload.
// Depends on fltw_pkg for field widths.
`default_nettype none

interface fltw_out_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [fltw_pkg::PA_W-1:0] read_address;
  logic [2:0]                status;
  logic [fltw_pkg::PA_W-1:0] paddr;
  logic                      writable;
  logic                      user;
  logic                      no_execute;
  logic                      write_through;
  logic                      cache_disable;
  logic                      global_page;
  logic                      accessed;
  logic                      dirty;

  modport source (output valid, output kind, output read_address, output status,
                  output paddr, output writable, output user,
                  output no_execute, output write_through, output cache_disable,
                  output global_page, output accessed, output dirty,
                  input ready);
  modport sink (input valid, input kind, input read_address, input status,
                input paddr, input writable, input user,
                input no_execute, input write_through, input cache_disable,
                input global_page, input accessed, input dirty,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fltw_cfg_regs.sv -----
// Configuration registers: root table address and the physical address mask.
// The mask is derived from the written width at write time. Uses fltw_pkg.
`default_nettype none

module fltw_cfg_regs #(
  parameter int unsigned PHYS_ADDR_BITS = 52
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [fltw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fltw_pkg::PA_W-1:0]       cfg_wdata,
  output fltw_pkg::cfg_t                       cfg
);

  localparam logic [fltw_pkg::PAB_W-1:0] PAB_MIN = fltw_pkg::PAB_W'(12);
  localparam logic [fltw_pkg::PAB_W-1:0] PAB_MAX = fltw_pkg::PAB_W'(PHYS_ADDR_BITS);
  localparam logic [fltw_pkg::PAB_W-1:0] PAB_RESET = fltw_pkg::PAB_W'(52);

  // Width is clamped to [12, PHYS_ADDR_BITS]; bits 11..0 of the mask stay clear.
  function automatic logic [fltw_pkg::PA_W-1:0] width_mask(
    input logic [fltw_pkg::PAB_W-1:0] bits
  );
    logic [fltw_pkg::PAB_W-1:0] b;
    logic [fltw_pkg::PA_W-1:0]  m;
    b = bits;
    if (b < PAB_MIN) b = PAB_MIN;
    if (b > PAB_MAX) b = PAB_MAX;
    for (int i = 0; i < int'(fltw_pkg::PA_W); i++) begin
      m[i] = (i >= 12) && (fltw_pkg::PAB_W'(i) < b);
    end
    return m;
  endfunction

  logic [fltw_pkg::PA_W-1:0] root_r;
  logic [fltw_pkg::PA_W-1:0] mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
      mask_r <= width_mask(PAB_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        fltw_pkg::REG_ROOT:   root_r <= cfg_wdata;
        fltw_pkg::REG_PABITS: mask_r <= width_mask(cfg_wdata[fltw_pkg::PAB_W-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg.root = root_r;
  assign cfg.mask = mask_r;

endmodule

`default_nettype wire

// ----- rtl/core/fltw_in_stage.sv -----
// Input register of the walker: holds one request until the walk step takes it.
// Uses fltw_pkg and the request channel interface.
`default_nettype none

module fltw_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  fltw_in_if.sink         in_ch,
  input  wire logic       take,      // step consumes the held request
  output logic            held_valid,
  output fltw_pkg::item_t held_item
);

  logic            valid_r;
  fltw_pkg::item_t item_r;
  logic            load;

  assign in_ch.ready = !valid_r || take;
  assign load = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.cmd         <= in_ch.cmd;
      item_r.vaddr       <= in_ch.vaddr;
      item_r.entry_value <= in_ch.entry_value;
    end
  end

  assign held_valid = valid_r;
  assign held_item = item_r;

endmodule

`default_nettype wire

// ----- rtl/core/fltw_walk.sv -----
// Walk state and the combinational step: canonical and root checks, entry checks,
// permission combining, next entry address and final physical address. Uses fltw_pkg.
`default_nettype none

module fltw_walk (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire fltw_pkg::cfg_t   cfg,
  input  wire logic             fire,
  input  wire fltw_pkg::item_t  item,
  output logic                  res_valid,
  output fltw_pkg::result_t     res
);

  logic                         busy_r, busy_nxt;
  logic [1:0]                   level_r, level_nxt;
  logic [fltw_pkg::SAVED_W-1:0] saved_r, saved_nxt;
  logic                         eff_w_r, eff_w_nxt;
  logic                         eff_u_r, eff_u_nxt;
  logic                         eff_nx_r, eff_nx_nxt;

  // 9-bit table index for a level, level 0 is the top table
  function automatic logic [8:0] level_index(
    input logic [fltw_pkg::SAVED_W-1:0] va,
    input logic [1:0]                   lvl
  );
    logic [8:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  logic [fltw_pkg::VA_W-1:0] e;
  logic [fltw_pkg::VA_W-1:0] va;
  logic                      noncanon;
  logic                      root_bad;
  logic                      rsvd;
  logic [fltw_pkg::PA_W-1:0] frame;
  logic [1:0]                level_inc;
  logic                      w_path, u_path, nx_path;

  always_comb begin
    e = item.entry_value;
    va = item.vaddr;
    noncanon = va[47] ? (va[63:48] != fltw_pkg::UPPER_ONES) : (va[63:48] != '0);
    root_bad = (cfg.root[11:0] != '0) || ((cfg.root & ~cfg.mask) != '0);
    rsvd = (e[51:12] & ~cfg.mask[51:12]) != '0;
    frame = e[fltw_pkg::PA_W-1:0] & cfg.mask;
    level_inc = level_r + 2'd1;
    w_path = eff_w_r && e[fltw_pkg::BIT_RW];
    u_path = eff_u_r && e[fltw_pkg::BIT_US];
    nx_path = eff_nx_r || e[fltw_pkg::BIT_NX];
  end

  always_comb begin
    busy_nxt = busy_r;
    level_nxt = level_r;
    saved_nxt = saved_r;
    eff_w_nxt = eff_w_r;
    eff_u_nxt = eff_u_r;
    eff_nx_nxt = eff_nx_r;
    res_valid = 1'b0;
    res = '0;

    if (fire) begin
      if (item.cmd == fltw_pkg::CMD_START) begin
        // a start always drops any walk in progress
        busy_nxt = 1'b0;
        level_nxt = 2'd0;
        res_valid = 1'b1;
        if (noncanon) begin
          res.kind = fltw_pkg::KIND_DONE;
          res.status = fltw_pkg::ST_NONCANON;
        end else if (root_bad) begin
          res.kind = fltw_pkg::KIND_DONE;
          res.status = fltw_pkg::ST_CORRUPT;
        end else begin
          saved_nxt = va[fltw_pkg::SAVED_W-1:0];
          eff_w_nxt = 1'b1;
          eff_u_nxt = 1'b1;
          eff_nx_nxt = 1'b0;
          busy_nxt = 1'b1;
          res.kind = fltw_pkg::KIND_REQ;
          res.read_address = cfg.root + {40'b0, va[47:39], 3'b000};
        end
      end else if (busy_r) begin
        res_valid = 1'b1;
        res.kind = fltw_pkg::KIND_DONE;
        if (!e[fltw_pkg::BIT_PRESENT]) begin
          busy_nxt = 1'b0;
          level_nxt = 2'd0;
          res.status = fltw_pkg::ST_NOTMAPPED;
        end else if (level_r != 2'd3) begin
          if (e[fltw_pkg::BIT_HUGE]) begin
            // huge page at the top table is never legal
            busy_nxt = 1'b0;
            level_nxt = 2'd0;
            res.status = (level_r == 2'd0) ? fltw_pkg::ST_CORRUPT : fltw_pkg::ST_HUGE;
          end else begin
            eff_w_nxt = w_path;
            eff_u_nxt = u_path;
            eff_nx_nxt = nx_path;
            if (rsvd) begin
              busy_nxt = 1'b0;
              level_nxt = 2'd0;
              res.status = fltw_pkg::ST_CORRUPT;
            end else begin
              level_nxt = level_inc;
              res.kind = fltw_pkg::KIND_REQ;
              res.read_address = frame + {40'b0, level_index(saved_r, level_inc), 3'b000};
            end
          end
        end else begin
          busy_nxt = 1'b0;
          level_nxt = 2'd0;
          if (rsvd) begin
            res.status = fltw_pkg::ST_CORRUPT;
          end else begin
            eff_w_nxt = w_path;
            eff_u_nxt = u_path;
            eff_nx_nxt = nx_path;
            res.status = fltw_pkg::ST_OK;
            res.paddr = frame + {40'b0, saved_r[11:0]};
            res.writable = w_path;
            res.user = u_path;
            res.no_execute = nx_path;
            res.write_through = e[fltw_pkg::BIT_PWT];
            res.cache_disable = e[fltw_pkg::BIT_PCD];
            res.global_page = e[fltw_pkg::BIT_GLOBAL];
            res.accessed = e[fltw_pkg::BIT_ACC];
            res.dirty = e[fltw_pkg::BIT_DIRTY];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      level_r <= 2'd0;
      saved_r <= '0;
      eff_w_r <= 1'b1;
      eff_u_r <= 1'b1;
      eff_nx_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      level_r <= level_nxt;
      saved_r <= saved_nxt;
      eff_w_r <= eff_w_nxt;
      eff_u_r <= eff_u_nxt;
      eff_nx_r <= eff_nx_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/fltw_out_stage.sv -----
// Result register of the walker: holds one result until the sink takes it.
// Uses fltw_pkg and the result channel interface.
`default_nettype none

module fltw_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_valid,
  input  wire fltw_pkg::result_t res,
  output logic                   free,      // a result may be loaded this cycle
  fltw_out_if.source             out_ch
);

  logic              valid_r;
  fltw_pkg::result_t res_r;
  logic              load;

  assign free = !valid_r || out_ch.ready;
  assign load = res_valid && free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.kind = res_r.kind;
  assign out_ch.read_address = res_r.read_address;
  assign out_ch.status = res_r.status;
  assign out_ch.paddr = res_r.paddr;
  assign out_ch.writable = res_r.writable;
  assign out_ch.user = res_r.user;
  assign out_ch.no_execute = res_r.no_execute;
  assign out_ch.write_through = res_r.write_through;
  assign out_ch.cache_disable = res_r.cache_disable;
  assign out_ch.global_page = res_r.global_page;
  assign out_ch.accessed = res_r.accessed;
  assign out_ch.dirty = res_r.dirty;

endmodule

`default_nettype wire

// ----- rtl/core/four_level_page_table_walker.sv -----
// Top level of the four-level page table walker.
// Instantiates fltw_cfg_regs, fltw_in_stage, fltw_walk and fltw_out_stage.
//
//   port group | dir | handshake      | payload
//   in_ch      | in  | valid / ready  | cmd, vaddr, entry_value
//   out_ch     | out | valid / ready  | kind, read_address, status, paddr, flags
//   cfg_*      | in  | cfg_we only    | cfg_index, cfg_wdata
//
// One request per cycle sustained unless out_ch stalls; each request passes through
// the input register, the walk step and then the result register on its way out.
// Entry returns while no walk is running produce no result.
// A stalled result holds in the result register; one more request still waits in
// the input register behind it. Synchronous reset: no walk, empty registers.
`default_nettype none

module four_level_page_table_walker #(
  parameter int unsigned PHYS_ADDR_BITS = 52
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  fltw_in_if.sink                             in_ch,
  fltw_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [fltw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fltw_pkg::PA_W-1:0]      cfg_wdata
);

  fltw_pkg::cfg_t    cfg;
  fltw_pkg::item_t   held_item;
  fltw_pkg::result_t res;
  logic              held_valid;
  logic              res_valid;
  logic              out_free;
  logic              fire;

  assign fire = held_valid && out_free;

  fltw_cfg_regs #(
    .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fltw_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  fltw_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .fire      (fire),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  fltw_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .free      (out_free),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ----- rtl/core/fltw_checker.sv -----
// Port-level checks of the page table walker result channel, bound to the top.
// Depends on fltw_pkg and four_level_page_table_walker.
`default_nettype none

module fltw_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      kind,
  input wire logic [fltw_pkg::PA_W-1:0] read_address,
  input wire logic [2:0]                status,
  input wire logic [fltw_pkg::PA_W-1:0] paddr,
  input wire logic [7:0]                flags
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(status)
      && $stable(read_address) && $stable(paddr))
    else $error("stalled result changed");

  a_request_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == fltw_pkg::KIND_REQ |->
      status == fltw_pkg::ST_OK && paddr == '0 && flags == '0)
    else $error("entry read request carries translation fields");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == fltw_pkg::KIND_DONE && status != fltw_pkg::ST_OK |->
      paddr == '0 && flags == '0 && read_address == '0)
    else $error("failed translation carries address or flags");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status == fltw_pkg::ST_OK || status == fltw_pkg::ST_NONCANON
      || status == fltw_pkg::ST_NOTMAPPED || status == fltw_pkg::ST_HUGE
      || status == fltw_pkg::ST_CORRUPT)
    else $error("undefined status code");

endmodule

bind four_level_page_table_walker fltw_checker u_fltw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .kind             (out_ch.kind),
  .read_address     (out_ch.read_address),
  .status           (out_ch.status),
  .paddr            (out_ch.paddr),
  .flags            ({out_ch.writable, out_ch.user, out_ch.no_execute,
                      out_ch.write_through, out_ch.cache_disable,
                      out_ch.global_page, out_ch.accessed, out_ch.dirty})
);

`default_nettype wire
